FILE: sv/vertex_transform_point_plot_macros.svh
// Assertion macros shared by the checker of the vertex transform block.
`ifndef VERTEX_TRANSFORM_POINT_PLOT_MACROS_SVH
`define VERTEX_TRANSFORM_POINT_PLOT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define VTP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define VTP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/vtp_pkg.sv
// Shared types, constants and helpers of the vertex transform block.
package vtp_pkg;

    localparam int SCREEN_WIDTH_DEF  = 64;
    localparam int SCREEN_HEIGHT_DEF = 24;

    localparam int IN_TDATA_W  = 192;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 32;
    localparam int IDX_W       = 11;
    localparam int DEP_W       = 16;

    localparam int DIV_NUM_W = 50;
    localparam int DIV_DEN_W = 34;
    localparam int ACC_W     = 50;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef enum logic [2:0] {
        OP_VERTEX    = 3'd0,
        OP_SEL_PROJ  = 3'd1,
        OP_SEL_MODEL = 3'd2,
        OP_IDENTITY  = 3'd3,
        OP_TRANSLATE = 3'd4,
        OP_SCALE     = 3'd5,
        OP_FRUSTUM   = 3'd6
    } op_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > ACC_W'(64'sd2147483647)) begin
            r = 32'sh7fff_ffff;
        end else if (v < ACC_W'(-64'sd2147483648)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/vtp_div.sv
// Radix-2 restoring divider: saturated trunc(num * 2^16 / den), zero for zero den.
module vtp_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [vtp_pkg::DIV_NUM_W-1:0] num,
    input  logic signed [vtp_pkg::DIV_DEN_W-1:0] den,
    output logic                                 done,
    output logic signed [31:0]                   quo
);
    import vtp_pkg::*;

    localparam int QW  = DIV_NUM_W + 16;
    localparam int CW  = $clog2(QW);

    logic                   busy_reg;
    logic                   fin_reg;
    logic                   done_reg;
    logic [CW-1:0]          cnt_reg;
    logic [QW-1:0]          sh_reg;
    logic [DIV_DEN_W:0]     rem_reg;
    logic [DIV_DEN_W-1:0]   den_reg;
    logic                   neg_reg;
    logic signed [31:0]     quo_reg;

    logic [DIV_DEN_W:0]     rem_sh;
    logic                   q_bit;
    logic [DIV_DEN_W:0]     rem_next;
    logic [DIV_NUM_W-1:0]   num_mag;
    logic [DIV_DEN_W-1:0]   den_mag;

    always_comb begin
        rem_sh   = {rem_reg[DIV_DEN_W-1:0], sh_reg[QW-1]};
        q_bit    = (rem_sh >= {1'b0, den_reg});
        rem_next = q_bit ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        num_mag  = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
        den_mag  = den[DIV_DEN_W-1] ? DIV_DEN_W'(-den) : DIV_DEN_W'(den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (start && den == '0) || (!start && !busy_reg && fin_reg);
            if (start) begin
                if (den == '0) begin
                    quo_reg  <= '0;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CW'(QW - 1);
                    sh_reg   <= {num_mag, 16'd0};
                    rem_reg  <= '0;
                    den_reg  <= den_mag;
                    neg_reg  <= num[DIV_NUM_W-1] ^ den[DIV_DEN_W-1];
                end
            end else if (busy_reg) begin
                sh_reg  <= {sh_reg[QW-2:0], q_bit};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                if (neg_reg) begin
                    quo_reg <= (sh_reg > QW'(64'h8000_0000)) ? 32'sh8000_0000
                                                             : -$signed(sh_reg[31:0]);
                end else begin
                    quo_reg <= (sh_reg > QW'(64'h7fff_ffff)) ? 32'sh7fff_ffff
                                                             : $signed(sh_reg[31:0]);
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: sv/vertex_transform_point_plot.sv
// Fixed-function vertex transform: matrix stack ops and per-vertex point plotting.
//
// Usage:
//   s_ channel carries one command item: s_tuser is the opcode, s_tdata the six Q16.16
//   operands. Opcodes select a matrix, load identity, right-multiply by translate or
//   scale, load a frustum, or transform a vertex by proj*model.
//   m_ channel carries one pixel item per plotted vertex: index and Q0.16 depth.
//   Vertices with w of zero or an index off screen produce no item.
//   One item is processed at a time; s_tready is high only while the sequencer is idle.
//   Work per vertex: PM product, clip transform, three divisions. Item time is set by
//   the shared 32x32 multiply-accumulate, each MAC passing through the matrix memory
//   read, multiply and accumulate states, and by the 66-step divider.
//   A vertex before any projection select returns index 0, depth 0.
//   Result sits in an output register; a stalled receiver holds it while the block
//   starts the next item, and the block waits only when a second result is ready.
//   Reset (aresetn low, synchronous) clears both matrices to zero through per-entry
//   valid bits, selects projection and clears the projection-seen flag.
module vertex_transform_point_plot #(
    parameter int SCREEN_WIDTH  = vtp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = vtp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // arg_a[31:0], arg_b[63:32], arg_c[95:64], arg_d[127:96], arg_e[159:128], arg_f[191:160]
    input  logic [vtp_pkg::IN_TDATA_W-1:0]     s_tdata,
    // opcode[2:0]
    input  logic [vtp_pkg::IN_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pixel_index[10:0], pixel_depth[26:11], zero[31:27]
    output logic [vtp_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import vtp_pkg::*;

    localparam int WW = $clog2(SCREEN_WIDTH + 1);
    localparam int HW = $clog2(SCREEN_HEIGHT + 1);
    localparam int XP = 34 + WW + 1;
    localparam int YP = 34 + HW + 1;
    localparam int IW = YP + WW + 2;
    localparam logic signed [WW:0]   W_S   = (WW + 1)'(SCREEN_WIDTH);
    localparam logic signed [HW:0]   H_S   = (HW + 1)'(SCREEN_HEIGHT);
    localparam logic signed [IW-1:0] PIX_N = IW'(SCREEN_WIDTH * SCREEN_HEIGHT);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MREAD, ST_MMUL, ST_MACC, ST_MWR, ST_CP_RD, ST_CP_WR, ST_IDENT,
        ST_FMUL, ST_DSTART, ST_DWAIT, ST_FWR, ST_PXY, ST_IDX, ST_OUT
    } state_t;

    typedef enum logic [1:0] {MD_PM, MD_UPD, MD_CLIP} mode_t;

    state_t                    state_reg;
    mode_t                     mode_reg;
    op_t                       op_reg;
    logic [3:0]                idx_reg;
    logic [1:0]                k_reg;
    logic [2:0]                j_reg;
    logic                      model_sel_reg;
    logic                      proj_seen_reg;
    logic signed [31:0]        arga_reg, argb_reg, argc_reg, argd_reg, arge_reg, argf_reg;
    logic signed [63:0]        prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [31:0]        clip_reg [4];
    logic signed [31:0]        fr_reg [6];
    logic signed [XP-1:0]      px_reg;
    logic signed [YP-1:0]      py_reg;
    logic [IDX_W-1:0]          res_idx_reg;
    logic [DEP_W-1:0]          res_dep_reg;
    logic                      m_valid_reg;
    logic [IDX_W-1:0]          m_idx_reg;
    logic [DEP_W-1:0]          m_dep_reg;

    logic signed [31:0]        proj_mem [16];
    logic signed [31:0]        model_mem [16];
    logic signed [31:0]        scr_mem [16];
    logic [15:0]               proj_vld_reg;
    logic [15:0]               model_vld_reg;
    logic signed [31:0]        proj_rd_reg, model_rd_reg, scr_rd_reg;
    logic                      proj_rdv_reg, model_rdv_reg;

    logic [3:0]                proj_raddr, model_raddr, scr_raddr;
    logic                      cur_we;
    logic signed [31:0]        cur_wdata;
    logic signed [31:0]        proj_val, model_val, cur_val, arg_k, tmat_v, opa, opb;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [31:0]        acc_sat;
    logic                      out_load;

    logic                      div_start;
    logic                      div_done;
    logic signed [31:0]        div_quo;
    logic signed [DIV_NUM_W-1:0] div_num;
    logic signed [DIV_DEN_W-1:0] div_den;

    logic signed [XP-1:0]      xprod, xadj;
    logic signed [YP-1:0]      yprod, yadj;
    logic signed [IW-1:0]      idx_full;
    logic signed [33:0]        dep34;
    logic [32:0]               dep_half;
    logic [DEP_W-1:0]          dep_sat;

    always_comb begin
        proj_val  = proj_rdv_reg ? proj_rd_reg : '0;
        model_val = model_rdv_reg ? model_rd_reg : '0;
        cur_val   = model_sel_reg ? model_val : proj_val;
        case (k_reg)
            2'd0:    arg_k = arga_reg;
            2'd1:    arg_k = argb_reg;
            2'd2:    arg_k = argc_reg;
            default: arg_k = Q_ONE;
        endcase
        if (op_reg == OP_TRANSLATE) begin
            tmat_v = (idx_reg[3:2] == 2'd3) ? arg_k : ((idx_reg[3:2] == k_reg) ? Q_ONE : '0);
        end else begin
            tmat_v = (idx_reg[3:2] == k_reg) ? arg_k : '0;
        end
        case (mode_reg)
            MD_PM: begin
                opa = proj_val;
                opb = model_val;
            end
            MD_UPD: begin
                opa = cur_val;
                opb = tmat_v;
            end
            default: begin
                opa = scr_rd_reg;
                opb = arg_k;
            end
        endcase
        acc_next = ((k_reg == 2'd0) ? ACC_W'(0) : acc_reg) + ACC_W'($signed(prod_reg[63:16]));
        acc_sat  = sat32(acc_reg);
    end

    always_comb begin
        proj_raddr  = {k_reg, idx_reg[1:0]};
        model_raddr = (mode_reg == MD_PM) ? {idx_reg[3:2], k_reg} : {k_reg, idx_reg[1:0]};
        scr_raddr   = (state_reg == ST_CP_RD) ? idx_reg : {k_reg, idx_reg[1:0]};
        cur_we      = 1'b0;
        cur_wdata   = '0;
        case (state_reg)
            ST_IDENT: begin
                cur_we    = 1'b1;
                cur_wdata = (idx_reg[3:2] == idx_reg[1:0]) ? Q_ONE : '0;
            end
            ST_CP_WR: begin
                cur_we    = 1'b1;
                cur_wdata = scr_rd_reg;
            end
            ST_FWR: begin
                cur_we = 1'b1;
                case (idx_reg)
                    4'd0:    cur_wdata = fr_reg[0];
                    4'd5:    cur_wdata = fr_reg[1];
                    4'd8:    cur_wdata = fr_reg[2];
                    4'd9:    cur_wdata = fr_reg[3];
                    4'd10:   cur_wdata = fr_reg[4];
                    4'd11:   cur_wdata = -Q_ONE;
                    4'd14:   cur_wdata = fr_reg[5];
                    default: cur_wdata = '0;
                endcase
            end
            default: begin
                cur_we = 1'b0;
            end
        endcase
    end

    // divider operands
    always_comb begin
        logic signed [DIV_DEN_W-1:0] two_e, bma, apb, dmc, dpc, fme, nfe;
        logic signed [DIV_NUM_W-1:0] nfn;
        two_e = DIV_DEN_W'(arge_reg) <<< 1;
        bma   = DIV_DEN_W'(argb_reg) - DIV_DEN_W'(arga_reg);
        apb   = DIV_DEN_W'(argb_reg) + DIV_DEN_W'(arga_reg);
        dmc   = DIV_DEN_W'(argd_reg) - DIV_DEN_W'(argc_reg);
        dpc   = DIV_DEN_W'(argd_reg) + DIV_DEN_W'(argc_reg);
        fme   = DIV_DEN_W'(argf_reg) - DIV_DEN_W'(arge_reg);
        nfe   = -(DIV_DEN_W'(argf_reg) + DIV_DEN_W'(arge_reg));
        nfn   = -(DIV_NUM_W'($signed(prod_reg[63:16])) <<< 1);
        if (op_reg == OP_VERTEX) begin
            div_num = DIV_NUM_W'(clip_reg[j_reg[1:0]]);
            div_den = DIV_DEN_W'(clip_reg[3]);
        end else begin
            case (j_reg)
                3'd0: begin
                    div_num = DIV_NUM_W'(two_e);
                    div_den = bma;
                end
                3'd1: begin
                    div_num = DIV_NUM_W'(two_e);
                    div_den = dmc;
                end
                3'd2: begin
                    div_num = DIV_NUM_W'(apb);
                    div_den = bma;
                end
                3'd3: begin
                    div_num = DIV_NUM_W'(dpc);
                    div_den = dmc;
                end
                3'd4: begin
                    div_num = DIV_NUM_W'(nfe);
                    div_den = fme;
                end
                default: begin
                    div_num = nfn;
                    div_den = fme;
                end
            endcase
        end
        div_start = (state_reg == ST_DSTART);
    end

    // viewport map and depth
    always_comb begin
        xprod    = XP'(34'(fr_reg[0]) + 34'sd65536) * XP'(W_S);
        xadj     = xprod + ((xprod < 0) ? XP'(131071) : XP'(0));
        yprod    = YP'(34'sd65536 - 34'(fr_reg[1])) * YP'(H_S);
        yadj     = yprod + ((yprod < 0) ? YP'(131071) : YP'(0));
        idx_full = IW'(px_reg) + IW'(py_reg) * IW'(W_S);
        dep34    = 34'(fr_reg[2]) + 34'sd65536;
        dep_half = dep34[33] ? 33'd0 : dep34[33:1];
        dep_sat  = (dep_half > 33'd65535) ? 16'hffff : dep_half[15:0];
    end

    vtp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (cur_we && !model_sel_reg) begin
            proj_mem[idx_reg] <= cur_wdata;
        end
        if (cur_we && model_sel_reg) begin
            model_mem[idx_reg] <= cur_wdata;
        end
        if (state_reg == ST_MWR && mode_reg != MD_CLIP) begin
            scr_mem[idx_reg] <= acc_sat;
        end
        proj_rd_reg  <= proj_mem[proj_raddr];
        model_rd_reg <= model_mem[model_raddr];
        scr_rd_reg   <= scr_mem[scr_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proj_vld_reg  <= '0;
            model_vld_reg <= '0;
            proj_rdv_reg  <= 1'b0;
            model_rdv_reg <= 1'b0;
        end else begin
            if (cur_we && !model_sel_reg) begin
                proj_vld_reg[idx_reg] <= 1'b1;
            end
            if (cur_we && model_sel_reg) begin
                model_vld_reg[idx_reg] <= 1'b1;
            end
            proj_rdv_reg  <= proj_vld_reg[proj_raddr];
            model_rdv_reg <= model_vld_reg[model_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MD_PM;
            op_reg        <= OP_VERTEX;
            idx_reg       <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            model_sel_reg <= 1'b0;
            proj_seen_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg   <= op_t'(s_tuser);
                        arga_reg <= s_tdata[31:0];
                        argb_reg <= s_tdata[63:32];
                        argc_reg <= s_tdata[95:64];
                        argd_reg <= s_tdata[127:96];
                        arge_reg <= s_tdata[159:128];
                        argf_reg <= s_tdata[191:160];
                        idx_reg  <= '0;
                        k_reg    <= '0;
                        j_reg    <= '0;
                        case (op_t'(s_tuser))
                            OP_VERTEX: begin
                                if (proj_seen_reg) begin
                                    mode_reg  <= MD_PM;
                                    state_reg <= ST_MREAD;
                                end else begin
                                    res_idx_reg <= '0;
                                    res_dep_reg <= '0;
                                    state_reg   <= ST_OUT;
                                end
                            end
                            OP_SEL_PROJ: begin
                                model_sel_reg <= 1'b0;
                                proj_seen_reg <= 1'b1;
                            end
                            OP_SEL_MODEL: begin
                                model_sel_reg <= 1'b1;
                            end
                            OP_IDENTITY: begin
                                state_reg <= ST_IDENT;
                            end
                            OP_TRANSLATE, OP_SCALE: begin
                                mode_reg  <= MD_UPD;
                                state_reg <= ST_MREAD;
                            end
                            OP_FRUSTUM: begin
                                state_reg <= ST_FMUL;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_MREAD: begin
                    state_reg <= ST_MMUL;
                end
                ST_MMUL: begin
                    prod_reg  <= opa * opb;
                    state_reg <= ST_MACC;
                end
                ST_MACC: begin
                    acc_reg <= acc_next;
                    if (k_reg == 2'd3) begin
                        state_reg <= ST_MWR;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_MREAD;
                    end
                end
                ST_MWR: begin
                    k_reg   <= '0;
                    idx_reg <= idx_reg + 1'b1;
                    case (mode_reg)
                        MD_PM: begin
                            state_reg <= ST_MREAD;
                            if (idx_reg == 4'hf) begin
                                mode_reg <= MD_CLIP;
                            end
                        end
                        MD_UPD: begin
                            state_reg <= (idx_reg == 4'hf) ? ST_CP_RD : ST_MREAD;
                        end
                        default: begin
                            clip_reg[idx_reg[1:0]] <= acc_sat;
                            if (idx_reg[1:0] != 2'd3) begin
                                state_reg <= ST_MREAD;
                            end else if (acc_sat == '0) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                j_reg     <= '0;
                                state_reg <= ST_DSTART;
                            end
                        end
                    endcase
                end
                ST_CP_RD: begin
                    state_reg <= ST_CP_WR;
                end
                ST_CP_WR: begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= (idx_reg == 4'hf) ? ST_IDLE : ST_CP_RD;
                end
                ST_IDENT: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == 4'hf) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FMUL: begin
                    prod_reg  <= argf_reg * arge_reg;
                    state_reg <= ST_DSTART;
                end
                ST_DSTART: begin
                    state_reg <= ST_DWAIT;
                end
                ST_DWAIT: begin
                    if (div_done) begin
                        fr_reg[j_reg] <= div_quo;
                        j_reg         <= j_reg + 1'b1;
                        if (op_reg == OP_VERTEX && j_reg == 3'd2) begin
                            state_reg <= ST_PXY;
                        end else if (op_reg != OP_VERTEX && j_reg == 3'd5) begin
                            idx_reg   <= '0;
                            state_reg <= ST_FWR;
                        end else begin
                            state_reg <= ST_DSTART;
                        end
                    end
                end
                ST_FWR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == 4'hf) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PXY: begin
                    px_reg    <= xadj >>> 17;
                    py_reg    <= yadj >>> 17;
                    state_reg <= ST_IDX;
                end
                ST_IDX: begin
                    res_idx_reg <= idx_full[IDX_W-1:0];
                    res_dep_reg <= dep_sat;
                    if (idx_full < 0 || idx_full >= PIX_N) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_idx_reg   <= res_idx_reg;
                        m_dep_reg   <= res_dep_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_dep_reg, m_idx_reg};

endmodule

FILE: sv/vtp_chk.sv
// Port-level assertion checker for the vertex transform block, bound to the top level.
`include "vertex_transform_point_plot_macros.svh"

module vtp_chk #(
    parameter int SCREEN_WIDTH  = vtp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = vtp_pkg::SCREEN_HEIGHT_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [vtp_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic [vtp_pkg::IN_TUSER_W-1:0]  s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [vtp_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import vtp_pkg::*;

    localparam int PIX_N = SCREEN_WIDTH * SCREEN_HEIGHT;

    logic in_sel_proj;
    logic in_vertex;
    logic s_data_seen;

    assign in_sel_proj = s_tvalid && s_tready && (s_tuser == OP_SEL_PROJ);
    assign in_vertex   = s_tvalid && s_tready && (s_tuser == OP_VERTEX);
    assign s_data_seen = ^s_tdata || !(^s_tdata);

    `VTP_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `VTP_ASSERT_NXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")
    `VTP_ASSERT_IMP(a_idx_range, aclk, aresetn, m_tvalid, ((m_tdata[10:0] < PIX_N) || (PIX_N >= 2048)) && (m_tdata[31:27] == 5'd0) && s_data_seen, "pixel out of range")
    `VTP_ASSERT_NXT(a_sel_fast, aclk, aresetn, in_sel_proj, s_tready, "select op not single cycle")
    `VTP_ASSERT_NXT(a_vtx_busy, aclk, aresetn, in_vertex, !s_tready, "vertex accepted without work")

endmodule

bind vertex_transform_point_plot vtp_chk #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_vtp_chk (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for the vertex transform point plotter: predicts pixel items.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import vtp_pkg::*;

    localparam int SW = 64;
    localparam int SH = 24;
    localparam int ITEM_CNT = 1650;
    localparam longint CYCLE_LIMIT = 64'd8_000_000;
    localparam int HOLD_CYCLES = 20000;
    localparam logic signed [31:0] QMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] QMIN = 32'sh8000_0000;

    typedef struct packed {
        op_t opcode;
        logic [5:0][31:0] args;
    } cmd_t;

    typedef struct packed {
        logic [10:0] index;
        logic [15:0] depth;
    } pixel_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [IN_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    vertex_transform_point_plot dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    cmd_t cmd_q[$];
    pixel_t pixel_q[$];
    int err_cnt = 0;
    longint cycle_cnt = 0;
    bit stim_done = 0;
    int hold_cnt = 0;

    // predictor state
    logic signed [31:0] proj_m[16];
    logic signed [31:0] model_m[16];
    bit sel_model;
    bit proj_seen;

    function automatic longint floor_mul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > longint'(QMAX)) return QMAX;
        if (v < longint'(QMIN)) return QMIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qdiv(longint num, longint den);
        longint ip, rem;
        if (den == 0) return 0;
        ip = num / den;
        rem = num % den;
        if (ip > 32768) return QMAX;
        if (ip < -32769) return QMIN;
        return clamp32(ip * 65536 + (rem * 65536) / den);
    endfunction

    function automatic void mat_product(output logic signed [31:0] dst[16],
                                        input logic signed [31:0] a[16],
                                        input logic signed [31:0] b[16]);
        longint s;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                s = 0;
                for (int k = 0; k < 4; k++) s += floor_mul(a[k*4+r], b[c*4+k]);
                dst[c*4+r] = clamp32(s);
            end
        end
    endfunction

    function automatic void set_identity(output logic signed [31:0] m[16]);
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? Q_ONE : 32'sd0;
    endfunction

    function automatic void apply_to_current(input logic signed [31:0] t[16], bit mult);
        logic signed [31:0] res[16];
        if (sel_model) begin
            if (mult) mat_product(res, model_m, t); else res = t;
            model_m = res;
        end else begin
            if (mult) mat_product(res, proj_m, t); else res = t;
            proj_m = res;
        end
    endfunction

    function automatic void predict_pixel(cmd_t cmd);
        logic signed [31:0] a, b, c, d, e, f;
        logic signed [31:0] t[16], pm[16], v[4], clip[4];
        logic signed [31:0] nx, ny, nz;
        longint s, px, py, idx, dep, fn;
        pixel_t pix;
        a = cmd.args[0]; b = cmd.args[1]; c = cmd.args[2];
        d = cmd.args[3]; e = cmd.args[4]; f = cmd.args[5];
        case (cmd.opcode)
            OP_VERTEX: begin
                if (!proj_seen) begin
                    pix = '0;
                    pixel_q.push_back(pix);
                    return;
                end
                mat_product(pm, proj_m, model_m);
                v[0] = a; v[1] = b; v[2] = c; v[3] = Q_ONE;
                for (int r = 0; r < 4; r++) begin
                    s = 0;
                    for (int k = 0; k < 4; k++) s += floor_mul(pm[k*4+r], v[k]);
                    clip[r] = clamp32(s);
                end
                if (clip[3] == 0) return;
                nx = qdiv(clip[0], clip[3]);
                ny = qdiv(clip[1], clip[3]);
                nz = qdiv(clip[2], clip[3]);
                px = (longint'(nx) + 65536) * SW / 131072;
                py = (65536 - longint'(ny)) * SH / 131072;
                idx = px + py * SW;
                if (idx < 0 || idx >= SW * SH) return;
                dep = longint'(nz) + 65536;
                if (dep < 0) dep = 0;
                dep = dep >>> 1;
                if (dep > 65535) dep = 65535;
                pix.index = idx[10:0];
                pix.depth = dep[15:0];
                pixel_q.push_back(pix);
            end
            OP_SEL_PROJ: begin
                sel_model = 0;
                proj_seen = 1;
            end
            OP_SEL_MODEL: sel_model = 1;
            OP_IDENTITY: begin
                set_identity(t);
                apply_to_current(t, 0);
            end
            OP_TRANSLATE: begin
                set_identity(t);
                t[12] = a; t[13] = b; t[14] = c;
                apply_to_current(t, 1);
            end
            OP_SCALE: begin
                set_identity(t);
                t[0] = a; t[5] = b; t[10] = c;
                apply_to_current(t, 1);
            end
            OP_FRUSTUM: begin
                fn = floor_mul(f, e);
                for (int i = 0; i < 16; i++) t[i] = 0;
                t[0] = qdiv(2 * longint'(e), longint'(b) - a);
                t[5] = qdiv(2 * longint'(e), longint'(d) - c);
                t[8] = qdiv(longint'(b) + a, longint'(b) - a);
                t[9] = qdiv(longint'(d) + c, longint'(d) - c);
                t[10] = qdiv(-(longint'(f) + e), longint'(f) - e);
                t[11] = -Q_ONE;
                t[14] = qdiv(-(2 * fn), longint'(f) - e);
                apply_to_current(t, 0);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    function automatic cmd_t make_cmd(op_t op, int a, int b, int c, int d, int e, int f);
        cmd_t cmd;
        cmd.opcode = op;
        cmd.args = {f, e, d, c, b, a};
        return cmd;
    endfunction

    function automatic int small_q();
        // Q16.16 in about [-4, 4]
        return int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
    endfunction

    function automatic int any_q();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return QMAX;
            2: return QMIN;
            default: return small_q();
        endcase
    endfunction

    function automatic cmd_t random_cmd();
        int pick;
        int n, fr;
        pick = $urandom_range(0, 99);
        if (pick < 55) return make_cmd(OP_VERTEX, small_q(), small_q(),
                                       int'($urandom_range(0, 6 * 65536)) - 5 * 65536,
                                       $urandom, $urandom, $urandom);
        if (pick < 60) return make_cmd(OP_VERTEX, any_q(), any_q(), any_q(),
                                       $urandom, $urandom, $urandom);
        if (pick < 64) return make_cmd(OP_SEL_PROJ, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom);
        if (pick < 70) return make_cmd(OP_SEL_MODEL, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom);
        if (pick < 76) return make_cmd(OP_IDENTITY, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom);
        if (pick < 84) return make_cmd(OP_TRANSLATE, small_q() / 4, small_q() / 4,
                                       small_q() / 4, $urandom, $urandom, $urandom);
        if (pick < 90) return make_cmd(OP_SCALE, $urandom_range(32768, 131072),
                                       $urandom_range(32768, 131072),
                                       $urandom_range(32768, 131072),
                                       $urandom, $urandom, $urandom);
        if (pick < 96) begin
            n = $urandom_range(16384, 131072);
            fr = n + $urandom_range(65536, 20 * 65536);
            return make_cmd(OP_FRUSTUM, -small_q() / 4 - 65536, small_q() / 4 + 65536,
                            -small_q() / 4 - 65536, small_q() / 4 + 65536, n, fr);
        end
        if (pick < 98) return make_cmd(OP_FRUSTUM, any_q(), any_q(), any_q(),
                                       any_q(), any_q(), any_q());
        return make_cmd(op_t'(3'd7), $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
    endfunction

    // stimulus
    initial begin
        proj_m = '{default: 0};
        model_m = '{default: 0};
        sel_model = 0;
        proj_seen = 0;
        // vertex before any projection select
        cmd_q.push_back(make_cmd(OP_VERTEX, QMAX, QMIN, 0, -1, 0, -1));
        cmd_q.push_back(make_cmd(OP_TRANSLATE, 65536, 65536, 65536, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_VERTEX, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(op_t'(3'd7), -1, -1, -1, -1, -1, -1));
        cmd_q.push_back(make_cmd(OP_SEL_PROJ, 0, 0, 0, 0, 0, 0));
        // zero projection: w is zero, dropped
        cmd_q.push_back(make_cmd(OP_VERTEX, 65536, 65536, 65536, 0, 0, 0));
        // degenerate frustum: zero denominators
        cmd_q.push_back(make_cmd(OP_FRUSTUM, 65536, 65536, 65536, 65536, 65536, 65536));
        cmd_q.push_back(make_cmd(OP_VERTEX, 0, 0, -65536, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_FRUSTUM, QMIN, QMAX, QMIN, QMAX, QMAX, QMIN));
        cmd_q.push_back(make_cmd(OP_VERTEX, QMAX, QMAX, QMIN, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_FRUSTUM, -65536, 65536, -65536, 65536, 65536,
                                 10 * 65536));
        cmd_q.push_back(make_cmd(OP_SEL_MODEL, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_IDENTITY, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_VERTEX, 0, 0, -2 * 65536, 0, 0, 0));
        // off screen to the left lands on the previous row
        cmd_q.push_back(make_cmd(OP_VERTEX, -3 * 65536, 0, -2 * 65536, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_VERTEX, 5 * 65536, 5 * 65536, -2 * 65536, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_VERTEX, 0, 0, -65536 / 2, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_SCALE, QMAX, QMIN, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_VERTEX, 65536, 65536, -2 * 65536, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_IDENTITY, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_TRANSLATE, QMIN, QMAX, -65536, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_VERTEX, QMAX, QMIN, QMAX, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_IDENTITY, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < ITEM_CNT; i++) cmd_q.push_back(random_cmd());
        stim_done = 1;
    end

    // driver: bursts with gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        cmd_t nxt;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_pixel(cmd_t'({op_t'(s_tuser), s_tdata}));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    nxt = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= nxt.opcode;
                    s_tdata <= nxt.args;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 600);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cycle_cnt > 20000 && hold_cnt < HOLD_CYCLES) begin
                hold_cnt <= hold_cnt + 1;
                m_tready <= 1'b0;
            end else case ((cycle_cnt / 3000) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin
        pixel_t want;
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_q.size() == 0) begin
                report_mismatch("unexpected item", m_tdata, 0);
            end else begin
                want = pixel_q.pop_front();
                if (m_tdata[10:0] != want.index)
                    report_mismatch("pixel_index", m_tdata[10:0], want.index);
                if (m_tdata[26:11] != want.depth)
                    report_mismatch("pixel_depth", m_tdata[26:11], want.depth);
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done && cmd_q.size() == 0 && !s_tvalid && pixel_q.size() == 0);
        repeat (1000) @(posedge aclk);
        if (err_cnt == 0 && pixel_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end
endmodule

FILE: vertex_transform_point_plot.f
+incdir+sv
sv/vtp_pkg.sv
sv/vtp_div.sv
sv/vertex_transform_point_plot.sv
sv/vtp_chk.sv
tb/tb_top.sv
